@@ design/crff_pkg.sv @@
// Package for the counter-based random float fill block.
// Holds hash constants, format codes, register indexes and the float helpers.
// Used by crff_attempt.sv and counter_random_float_fill.sv.
package crff_pkg;

   localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_M1 = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_M2 = 64'h94D049BB133111EB;
   localparam int unsigned MAX_ATTEMPTS_DEF = 8;
   // cycles from a lane's counter input to its next counter and its verdict
   localparam int unsigned LANE_LAT = 16;

   typedef enum logic [1:0] {
      FMT_F16  = 2'd0,
      FMT_BF16 = 2'd1,
      FMT_F32  = 2'd2,
      FMT_F32X = 2'd3
   } fmt_type;

   localparam logic [1:0] REG_SEED  = 2'd0;
   localparam logic [1:0] REG_SCALE = 2'd1;
   localparam logic [1:0] REG_DTYPE = 2'd2;

   // Low 64 bits of a 64x64-bit product, built from 32x32 partials.
   function automatic logic [63:0] mul_lo64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] p0;
      logic [63:0] p1;
      logic [63:0] p2;
      p0 = {32'd0, a[31:0]} * {32'd0, b[31:0]};
      p1 = {32'd0, a[31:0]} * {32'd0, b[63:32]};
      p2 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
      return p0 + {p1[31:0], 32'd0} + {p2[31:0], 32'd0};
   endfunction

   // Narrow float32 to fp16 with round to nearest even.
   function automatic logic [15:0] f32_to_f16(input logic [31:0] x);
      logic [15:0] sgn;
      logic [7:0]  ex;
      logic [22:0] man;
      logic [8:0]  e;
      logic [23:0] m;
      logic [4:0]  sh;
      logic [23:0] q;
      logic [23:0] rem;
      logic [23:0] half;
      sgn  = {x[31], 15'd0};
      ex   = x[30:23];
      man  = x[22:0];
      e    = {1'b0, ex} - 9'd112;
      m    = {1'b1, man};
      q    = 24'd0;
      rem  = 24'd0;
      half = 24'd0;
      sh   = 5'd0;
      if (ex == 8'hFF) begin
         return sgn | 16'h7C00 | ((man != 23'd0) ? 16'h0200 : 16'h0000);
      end
      if (ex == 8'd0) begin
         return sgn;
      end
      if (ex >= 8'd143) begin
         return sgn | 16'h7C00;
      end
      if (ex <= 8'd112) begin
         if ((8'd126 - ex) > 8'd24) begin
            return sgn;
         end
         sh   = 5'(8'd126 - ex);
         q    = m >> sh;
         rem  = m & ((24'd1 << sh) - 24'd1);
         half = 24'd1 << (sh - 5'd1);
      end else begin
         q    = {9'd0, e[4:0], man[22:13]};
         rem  = {11'd0, man[12:0]};
         half = 24'h1000;
      end
      if (rem > half || (rem == half && q[0])) begin
         q = q + 24'd1;
      end
      return sgn | q[15:0];
   endfunction

   // Narrow float32 to bf16 with round to nearest even.
   function automatic logic [15:0] f32_to_bf16(input logic [31:0] x);
      logic [32:0] s;
      if (x[30:23] == 8'hFF && x[22:0] != 23'd0) begin
         return {x[31], 15'h7FC0};
      end
      s = {1'b0, x} + 33'h7FFF + {32'd0, x[16]};
      return s[31:16];
   endfunction

endpackage

@@ design/crff_fmul.sv @@
// Float32 multiplier with round to nearest even, three register stages.
// Depends on nothing but the clock; stalls never occur on this path.
module crff_fmul (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] p
);
   // stage 1: unpack, multiply mantissas
   logic        s1_sign_ff;
   logic signed [10:0] s1_exp_ff;
   logic [47:0] s1_mant_ff;
   logic        s1_nan_ff, s1_inf_ff, s1_zero_ff;
   logic        sgn, an, bn, ai, bi, az, bz;
   logic [23:0] ma, mb;
   logic signed [10:0] ea, eb;
   logic [5:0]  lza, lzb;

   function automatic logic [5:0] lz24(input logic [23:0] v);
      logic [5:0] n;
      n = 6'd24;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) n = 6'(23 - i);
      end
      return n;
   endfunction

   always_comb begin
      sgn = a[31] ^ b[31];
      an  = a[30:23] == 8'hFF && a[22:0] != 0;
      bn  = b[30:23] == 8'hFF && b[22:0] != 0;
      ai  = a[30:23] == 8'hFF && a[22:0] == 0;
      bi  = b[30:23] == 8'hFF && b[22:0] == 0;
      az  = a[30:0] == 0;
      bz  = b[30:0] == 0;
      ma  = (a[30:23] == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
      mb  = (b[30:23] == 0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
      lza = lz24(ma);
      lzb = lz24(mb);
      ea  = (a[30:23] == 0) ? 11'sd1 : $signed({3'd0, a[30:23]});
      eb  = (b[30:23] == 0) ? 11'sd1 : $signed({3'd0, b[30:23]});
      ma  = (lza < 6'd24) ? (ma << lza[4:0]) : ma;
      mb  = (lzb < 6'd24) ? (mb << lzb[4:0]) : mb;
      ea  = ea - $signed({5'd0, lza});
      eb  = eb - $signed({5'd0, lzb});
   end

   always_ff @(posedge clock) begin
      s1_sign_ff <= sgn;
      s1_exp_ff  <= ea + eb - 11'sd127;
      s1_mant_ff <= ma * mb;
      s1_nan_ff  <= an || bn || (ai && bz) || (bi && az);
      s1_inf_ff  <= ai || bi;
      s1_zero_ff <= az || bz;
   end

   // stage 2: normalize, shift right into subnormal range with sticky
   logic [26:0] s2_mant_ff;
   logic signed [10:0] s2_exp_ff;
   logic        s2_sign_ff, s2_nan_ff, s2_inf_ff, s2_zero_ff;
   logic [47:0] nm;
   logic signed [10:0] ne;
   logic [26:0] sm;
   logic [5:0]  rs;

   always_comb begin
      if (s1_mant_ff[47]) begin
         nm = s1_mant_ff;
         ne = s1_exp_ff + 11'sd1;
      end else begin
         nm = s1_mant_ff << 1;
         ne = s1_exp_ff;
      end
      // nm[47] is the leading one, value = 1.x * 2^(ne-127)
      sm = {nm[47:22], nm[21:0] != 0};
      rs = 6'd0;
      if (ne < 11'sd1) begin
         rs = (ne < -11'sd26) ? 6'd27 : 6'(11'sd1 - ne);
         sm = (rs >= 6'd27) ? {26'd0, nm != 0}
              : ({nm[47:22], nm[21:0] != 0} >> rs) |
                {26'd0, (({nm[47:22], nm[21:0] != 0} & ((27'd1 << rs) - 27'd1)) != 0)};
         ne = 11'sd0;
      end
   end

   always_ff @(posedge clock) begin
      s2_mant_ff <= sm;
      s2_exp_ff  <= ne;
      s2_sign_ff <= s1_sign_ff;
      s2_nan_ff  <= s1_nan_ff;
      s2_inf_ff  <= s1_inf_ff;
      s2_zero_ff <= s1_zero_ff;
   end

   // stage 3: round and pack
   logic [24:0] rm;
   logic [31:0] res;
   logic        up;
   logic [8:0]  fe;

   always_comb begin
      up = s2_mant_ff[2] && (s2_mant_ff[1] || s2_mant_ff[0] || s2_mant_ff[3]);
      rm = {1'b0, s2_mant_ff[26:3]} + {24'd0, up};
      fe = s2_exp_ff[8:0];
      if (s2_exp_ff == 0) begin
         // subnormal: carry into bit 23 makes it normal
         res = {s2_sign_ff, 8'(rm[23]), rm[22:0]};
      end else if (rm[24]) begin
         fe  = fe + 9'd1;
         res = {s2_sign_ff, fe[7:0], rm[23:1]};
      end else begin
         res = {s2_sign_ff, fe[7:0], rm[22:0]};
      end
      if (s2_exp_ff != 0 && (s2_exp_ff > 11'sd254 || (rm[24] && s2_exp_ff == 11'sd254))) begin
         res = {s2_sign_ff, 8'hFF, 23'd0};
      end
      if (s2_zero_ff) res = {s2_sign_ff, 31'd0};
      if (s2_inf_ff)  res = {s2_sign_ff, 8'hFF, 23'd0};
      if (s2_nan_ff)  res = 32'h7FC00000;
   end

   always_ff @(posedge clock) begin
      p <= res;
   end
endmodule

@@ design/crff_attempt.sv @@
// One attempt lane: hash the counter, form u*scale, narrow and check it.
// Depends on crff_pkg and crff_fmul. Fixed latency, no stall.
module crff_attempt (
   input  logic        clock,
   input  logic [63:0] seed,
   input  logic [31:0] scale,
   input  logic [1:0]  dtype,
   input  logic [63:0] ctr,
   output logic [63:0] ctr_next,
   output logic [31:0] nb,
   output logic        ok
);
   localparam int unsigned LAT = crff_pkg::LANE_LAT;

   // mix stages: add, xs30, mul, xs27, mul, xs31 for all three hashes (two for the value, one for the next counter)
   logic [63:0] a1_ff, a2_ff, a3_ff, a4_ff, b1_ff, b2_ff, b3_ff, b4_ff, h_ff;
   logic [63:0] n1_ff, n2_ff, n3_ff, n4_ff, nx_ff;
   logic [63:0] xa, xb, xn;
   always_comb begin
      xa = ctr + crff_pkg::GOLDEN;
      xb = b1_ff + crff_pkg::GOLDEN;
      xn = ctr + crff_pkg::GOLDEN + crff_pkg::GOLDEN;
   end
   always_ff @(posedge clock) begin
      a1_ff <= xa ^ (xa >> 30);
      a2_ff <= crff_pkg::mul_lo64(a1_ff, crff_pkg::MIX_M1);
      a3_ff <= a2_ff ^ (a2_ff >> 27);
      a4_ff <= crff_pkg::mul_lo64(a3_ff, crff_pkg::MIX_M2);
      b1_ff <= seed ^ (a4_ff ^ (a4_ff >> 31)) ;
      b2_ff <= crff_pkg::mul_lo64(xb ^ (xb >> 30), crff_pkg::MIX_M1);
      b3_ff <= b2_ff ^ (b2_ff >> 27);
      b4_ff <= crff_pkg::mul_lo64(b3_ff, crff_pkg::MIX_M2);
      h_ff  <= b4_ff ^ (b4_ff >> 31);
      n1_ff <= xn ^ (xn >> 30);
      n2_ff <= crff_pkg::mul_lo64(n1_ff, crff_pkg::MIX_M1);
      n3_ff <= n2_ff ^ (n2_ff >> 27);
      n4_ff <= crff_pkg::mul_lo64(n3_ff, crff_pkg::MIX_M2);
      nx_ff <= n4_ff ^ (n4_ff >> 31);
   end

   // u = k/2^23 - 1, exact in float32
   logic [31:0] u_ff;
   logic [24:0] d;
   logic [23:0] mag;
   logic [4:0]  lz;
   logic        neg;
   always_comb begin
      d   = {1'b0, h_ff[63:40]} - 25'h0800000;
      neg = d[24];
      mag = neg ? 24'(-d) : d[23:0];
      lz  = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (mag[i]) lz = 5'(23 - i);
      end
   end
   always_ff @(posedge clock) begin
      if (mag == 0) u_ff <= 32'd0;
      else begin
         u_ff <= {neg, 8'(8'd127 - {3'd0, lz}), 23'(mag << (lz + 5'd0)) };
      end
   end

   logic [31:0] prod;
   crff_fmul u_mul (.clock(clock), .a(u_ff), .b(scale), .p(prod));

   logic [31:0] nb_c;
   logic [7:0]  ex;
   logic        ok_c;
   logic [15:0] h16;
   always_comb begin
      nb_c = prod;
      ok_c = 1'b1;
      unique case (dtype)
         crff_pkg::FMT_F16: begin
            h16  = crff_pkg::f32_to_f16(prod);
            nb_c = {16'd0, h16};
            ok_c = !(h16[14:10] == 5'h1F || (h16[14:10] == 0 && h16[9:0] != 0));
            ex   = 8'd0;
         end
         crff_pkg::FMT_BF16: begin
            h16  = crff_pkg::f32_to_bf16(prod);
            nb_c = {16'd0, h16};
            ok_c = !(h16[14:7] == 8'hFF || (h16[14:7] == 0 && h16[6:0] != 0));
            ex   = 8'd0;
         end
         default: begin
            h16  = 16'd0;
            ex   = prod[30:23];
            ok_c = !(ex == 8'hFF || (ex == 0 && prod[22:0] != 0));
         end
      endcase
   end

   // delay the verdict so it lines up with the next counter at lane latency
   logic [31:0] nb_d_ff [2];
   logic        ok_d_ff [2];
   always_ff @(posedge clock) begin
      nb_d_ff[0] <= nb_c;
      ok_d_ff[0] <= ok_c;
      nb_d_ff[1] <= nb_d_ff[0];
      ok_d_ff[1] <= ok_d_ff[0];
      nb <= nb_d_ff[1];
      ok <= ok_d_ff[1];
   end

   // delay next counter to lane latency
   logic [63:0] dl_ff [LAT-5];
   always_ff @(posedge clock) begin
      dl_ff[0] <= nx_ff;
      for (int i = 1; i < LAT - 5; i++) dl_ff[i] <= dl_ff[i-1];
   end
   assign ctr_next = dl_ff[LAT-6];
endmodule

@@ design/counter_random_float_fill.sv @@
// Top level of the counter-based random float fill block.
// Depends on crff_pkg and crff_attempt; holds the CSR port and the lane chain.
//
// Usage: pulse req_start with req_element_index while req_busy is low; busy
// never rises, so one request may enter every cycle. Each request's result
// passes the lane chain and an output register and is shown for one cycle
// with rsp_valid. Attempts run as a chain of unrolled lanes, 16 stages each
// (two hash multiplies per mix, float multiply, narrowing); a later lane's
// answer is used only if every earlier lane failed.
// Throughput is one request per cycle. Reset clears valid bits and the CSRs
// (seed 0, scale 0.125, dtype fp16). The receiver cannot stall: results are
// taken in the cycle they appear. Write CSRs only while idle.
module counter_random_float_fill #(
   parameter int unsigned MAX_ATTEMPTS = crff_pkg::MAX_ATTEMPTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        req_busy,
   input  logic [47:0] req_element_index,
   output logic        rsp_valid,
   output logic [31:0] rsp_value_bits,
   output logic        rsp_retries_exhausted,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   localparam int unsigned LAT = crff_pkg::LANE_LAT;

   logic [63:0] seed_ff;
   logic [31:0] scale_ff;
   logic [1:0]  dtype_ff;
   logic        wr;
   assign csr_pready = 1'b1;
   assign req_busy   = 1'b0;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 64'd0;
         scale_ff <= 32'h3E000000;
         dtype_ff <= crff_pkg::FMT_F16;
      end else if (wr) begin
         if (csr_paddr[4:3] == crff_pkg::REG_SEED)  seed_ff  <= csr_pwdata;
         if (csr_paddr[4:3] == crff_pkg::REG_SCALE) scale_ff <= csr_pwdata[31:0];
         if (csr_paddr[4:3] == crff_pkg::REG_DTYPE) dtype_ff <= csr_pwdata[1:0];
      end
   end

   // read back
   always_comb begin
      unique case (csr_paddr[4:3])
         crff_pkg::REG_SEED:  csr_prdata = seed_ff;
         crff_pkg::REG_SCALE: csr_prdata = {32'd0, scale_ff};
         crff_pkg::REG_DTYPE: csr_prdata = {62'd0, dtype_ff};
         default:             csr_prdata = 64'd0;
      endcase
   end

   // lane chain: each lane sees the previous lane's next counter
   logic [63:0] ctr   [MAX_ATTEMPTS+1];
   logic [31:0] nb    [MAX_ATTEMPTS];
   logic        ok    [MAX_ATTEMPTS];
   logic [31:0] acc_v [MAX_ATTEMPTS+1];
   logic        acc_d [MAX_ATTEMPTS+1];
   logic        vld_ff [MAX_ATTEMPTS*LAT+1];

   assign ctr[0]   = {16'd0, req_element_index};
   assign acc_v[0] = 32'd0;
   assign acc_d[0] = 1'b0;

   for (genvar g = 0; g < MAX_ATTEMPTS; g++) begin : g_lane
      logic [31:0] pv_ff [LAT];
      logic        pd_ff [LAT];
      crff_attempt u_att (
         .clock(clock), .seed(seed_ff), .scale(scale_ff), .dtype(dtype_ff),
         .ctr(ctr[g]), .ctr_next(ctr[g+1]), .nb(nb[g]), .ok(ok[g])
      );
      // carry the earlier decision alongside this lane
      always_ff @(posedge clock) begin
         pv_ff[0] <= acc_v[g];
         pd_ff[0] <= acc_d[g];
         for (int i = 1; i < LAT; i++) begin
            pv_ff[i] <= pv_ff[i-1];
            pd_ff[i] <= pd_ff[i-1];
         end
      end
      assign acc_d[g+1] = pd_ff[LAT-1] || ok[g];
      assign acc_v[g+1] = pd_ff[LAT-1] ? pv_ff[LAT-1] : nb[g];
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= MAX_ATTEMPTS*LAT; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= req_start;
         for (int i = 1; i <= MAX_ATTEMPTS*LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   logic [31:0] out_v_ff;
   logic        out_x_ff;
   always_ff @(posedge clock) begin
      out_v_ff <= acc_d[MAX_ATTEMPTS] ? acc_v[MAX_ATTEMPTS] : 32'd0;
      out_x_ff <= !acc_d[MAX_ATTEMPTS];
   end
   assign rsp_valid             = vld_ff[MAX_ATTEMPTS*LAT];
   assign rsp_value_bits        = out_v_ff;
   assign rsp_retries_exhausted = out_x_ff;
endmodule
